// ===== rtl/core/prm_pkg.sv =====
package prm_pkg;

    // Coordinate and result geometry.
    localparam int COORD_BITS   = 20;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_VERTICES = 4096;

    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int PROD_W  = 2 * COORD_BITS + 1;
    localparam int CROSS_W = 53;
    localparam int AREA_W  = 52;
    localparam int LEN_W   = 41;

    // The square root works on two radicand bits per step; the radicand is the
    // sum of squares followed by two fraction bits per result fraction bit.
    localparam int RAD_PAIRS  = (PROD_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W      = 2 * RAD_PAIRS;
    localparam int RAD_PAD_W  = RAD_W - PROD_W - 2 * FRAC_BITS;
    localparam int ROOT_W     = RAD_PAIRS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int MUL_CNT_W  = $clog2(COORD_BITS);
    localparam int ROOT_CNT_W = $clog2(RAD_PAIRS);

    // Stream packing.
    localparam int IN_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * COORD_BITS + AREA_W + 1 + LEN_W + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== rtl/core/prm_seg_mac.sv =====
// Bit-serial multiply-accumulate for one edge: the shoelace cross term
// ax*by - ay*bx and the squared length dx*dx + dy*dy, one multiplier bit per cycle.
module prm_seg_mac import prm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_coord                   i_ax,
    input  t_coord                   i_ay,
    input  t_coord                   i_bx,
    input  t_coord                   i_by,
    output logic signed [PROD_W-1:0] o_cross,
    output logic [PROD_W-1:0]        o_sumsq,
    output t_unit_stat               o_stat
);

    logic                     r_busy;
    logic                     r_done;
    logic [MUL_CNT_W-1:0]     r_cnt;
    logic [COORD_BITS-1:0]    r_mplr_by;
    logic [COORD_BITS-1:0]    r_mplr_bx;
    logic [COORD_BITS-1:0]    r_mplr_dx;
    logic [COORD_BITS-1:0]    r_mplr_dy;
    logic signed [PROD_W-1:0] r_mcand_ax;
    logic signed [PROD_W-1:0] r_mcand_ay;
    logic [PROD_W-1:0]        r_mcand_dx;
    logic [PROD_W-1:0]        r_mcand_dy;
    logic signed [PROD_W-1:0] r_cross;
    logic [PROD_W-1:0]        r_sumsq;

    logic signed [PROD_W-1:0] n_cross;
    logic [PROD_W-1:0]        n_sumsq;
    logic signed [COORD_BITS:0] w_diff_x;
    logic signed [COORD_BITS:0] w_diff_y;
    logic [COORD_BITS:0]      w_abs_x;
    logic [COORD_BITS:0]      w_abs_y;
    logic                     w_sign_step;
    logic signed [PROD_W-1:0] w_pp_a;
    logic signed [PROD_W-1:0] w_pp_b;
    logic [PROD_W-1:0]        w_sq_x;
    logic [PROD_W-1:0]        w_sq_y;

    assign w_diff_x = {i_bx[COORD_BITS-1], i_bx} - {i_ax[COORD_BITS-1], i_ax};
    assign w_diff_y = {i_by[COORD_BITS-1], i_by} - {i_ay[COORD_BITS-1], i_ay};
    assign w_abs_x  = w_diff_x[COORD_BITS] ? (~w_diff_x + 1'b1) : w_diff_x;
    assign w_abs_y  = w_diff_y[COORD_BITS] ? (~w_diff_y + 1'b1) : w_diff_y;

    // The sign bit of a two's complement multiplier carries negative weight.
    assign w_sign_step = (r_cnt == MUL_CNT_W'(COORD_BITS - 1));
    assign w_pp_a      = r_mplr_by[0] ? r_mcand_ax : '0;
    assign w_pp_b      = r_mplr_bx[0] ? r_mcand_ay : '0;
    assign w_sq_x      = r_mplr_dx[0] ? r_mcand_dx : '0;
    assign w_sq_y      = r_mplr_dy[0] ? r_mcand_dy : '0;

    always_comb begin
        if (w_sign_step) begin
            n_cross = r_cross + (w_pp_b - w_pp_a);
        end else begin
            n_cross = r_cross + (w_pp_a - w_pp_b);
        end
        n_sumsq = r_sumsq + w_sq_x + w_sq_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_sign_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mplr_by  <= i_by;
            r_mplr_bx  <= i_bx;
            r_mplr_dx  <= w_abs_x[COORD_BITS-1:0];
            r_mplr_dy  <= w_abs_y[COORD_BITS-1:0];
            r_mcand_ax <= {{(PROD_W - COORD_BITS){i_ax[COORD_BITS-1]}}, i_ax};
            r_mcand_ay <= {{(PROD_W - COORD_BITS){i_ay[COORD_BITS-1]}}, i_ay};
            r_mcand_dx <= {{(PROD_W - COORD_BITS){1'b0}}, w_abs_x[COORD_BITS-1:0]};
            r_mcand_dy <= {{(PROD_W - COORD_BITS){1'b0}}, w_abs_y[COORD_BITS-1:0]};
            r_cross    <= '0;
            r_sumsq    <= '0;
        end else if (r_busy) begin
            r_mplr_by  <= r_mplr_by >> 1;
            r_mplr_bx  <= r_mplr_bx >> 1;
            r_mplr_dx  <= r_mplr_dx >> 1;
            r_mplr_dy  <= r_mplr_dy >> 1;
            r_mcand_ax <= r_mcand_ax <<< 1;
            r_mcand_ay <= r_mcand_ay <<< 1;
            r_mcand_dx <= r_mcand_dx << 1;
            r_mcand_dy <= r_mcand_dy << 1;
            r_cross    <= n_cross;
            r_sumsq    <= n_sumsq;
        end
    end

    assign o_cross     = r_cross;
    assign o_sumsq     = r_sumsq;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/core/prm_root.sv =====
// Restoring square root, one result bit per cycle, with FRAC_BITS fraction bits.
module prm_root import prm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_radicand,
    output logic [ROOT_W-1:0] o_root,
    output t_unit_stat        o_stat
);

    logic                  r_busy;
    logic                  r_done;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;

    logic                  w_last_step;
    logic [REM_W-1:0]      w_rem_sh;
    logic [REM_W-1:0]      w_trial;
    logic                  w_ge;
    logic [REM_W-1:0]      n_rem;

    assign w_last_step = (r_cnt == ROOT_CNT_W'(RAD_PAIRS - 1));
    assign w_rem_sh    = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial     = {r_root, 2'b01};
    assign w_ge        = (w_rem_sh >= w_trial);
    assign n_rem       = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {{RAD_PAD_W{1'b0}}, i_radicand, {(2 * FRAC_BITS){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/core/polygon_ring_metrics_top.sv =====
// Polygon ring metrics: bounding box, shoelace area and perimeter of a shape.
// Vertices enter on the slave stream, one transfer per vertex, with tlast on
// the final vertex of the shape. Each shape yields one result transfer on the
// master stream carrying the box, twice the absolute area, the clockwise flag,
// the perimeter in fixed point, the vertex count and the overflow flag.
// The configuration channel sets ring mode; it is always ready and should be
// written only while no shape is in flight.
// The first vertex of a shape is only stored. Every further vertex runs a
// bit-serial multiply for the cross and squared terms, then a restoring square
// root for the segment length; no new vertex is accepted until it is done.
// The last vertex then runs the closing edge, with the square root only in
// ring mode, before the result is registered.
// Vertices past MAX_VERTICES are dropped and reported through the overflow flag.
// Reset (synchronous, active low) clears the shape, ring mode and the result.
// While the receiver stalls, the result is held in the output register and
// vertices of the next shape are still accepted; only a new result waits.
module polygon_ring_metrics_top import prm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Vertex stream. tdata: vertex_x [19:0], vertex_y [39:20].
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,
    // Result stream. tdata: box_min_x [19:0], box_max_x [39:20],
    // box_min_y [59:40], box_max_y [79:60], double_area [131:80],
    // is_clockwise [132], perimeter [173:133], vertex_total [186:174],
    // overflowed [187], zero fill [191:188].
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration: ring_mode.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LAUNCH = 5'b00010,
        S_MUL    = 5'b00100,
        S_ROOT   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;

    // Shape state.
    logic                      r_ring;
    logic [CNT_W-1:0]          r_count;
    logic                      r_overflow;
    logic signed [CROSS_W-1:0] r_cross_sum;
    logic [LEN_W-1:0]          r_len_sum;
    t_coord                    r_first_x;
    t_coord                    r_first_y;
    t_coord                    r_prev_x;
    t_coord                    r_prev_y;
    t_coord                    r_min_x;
    t_coord                    r_max_x;
    t_coord                    r_min_y;
    t_coord                    r_max_y;

    // Job control: the current edge is the closing edge, it adds to the
    // perimeter, and a closing edge is still to follow.
    logic                      r_job_close;
    logic                      r_job_len;
    logic                      r_pend_close;

    // Result register.
    logic                      r_out_valid;
    t_coord                    r_res_min_x;
    t_coord                    r_res_max_x;
    t_coord                    r_res_min_y;
    t_coord                    r_res_max_y;
    logic [AREA_W-1:0]         r_res_area;
    logic                      r_res_cw;
    logic [LEN_W-1:0]          r_res_perim;
    logic [CNT_W-1:0]          r_res_total;
    logic                      r_res_ovf;

    t_coord                    w_in_x;
    t_coord                    w_in_y;
    logic                      w_in_fire;
    logic                      w_full;
    logic                      w_take;
    logic                      w_edge;
    logic                      w_emit;
    logic                      w_mac_start;
    logic                      w_root_start;
    t_coord                    w_op_bx;
    t_coord                    w_op_by;
    logic signed [PROD_W-1:0]  w_cross;
    logic [PROD_W-1:0]         w_sumsq;
    logic [ROOT_W-1:0]         w_root;
    t_unit_stat                w_mac_stat;
    t_unit_stat                w_root_stat;
    logic signed [CROSS_W:0]   w_cross_ext;
    logic signed [CROSS_W-1:0] w_cross_sat;
    logic [LEN_W:0]            w_len_ext;
    logic [LEN_W-1:0]          w_len_sat;
    logic [CROSS_W-1:0]        w_abs;
    logic [AREA_W-1:0]         w_area;

    assign w_in_x    = i_s_axis_tdata[COORD_BITS-1:0];
    assign w_in_y    = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;

    assign w_in_fire = i_s_axis_tvalid & o_s_axis_tready;
    assign w_full    = (r_count >= CNT_W'(MAX_VERTICES));
    assign w_take    = w_in_fire & ~w_full;
    assign w_edge    = w_take & (r_count != '0);
    assign w_emit    = (r_state == S_EMIT) & (~r_out_valid | i_m_axis_tready);

    // An edge always starts at the previous vertex; it ends at the new vertex,
    // or at the first vertex for the closing edge.
    assign w_mac_start  = w_edge | (r_state == S_LAUNCH);
    assign w_op_bx      = (r_state == S_LAUNCH) ? r_first_x : w_in_x;
    assign w_op_by      = (r_state == S_LAUNCH) ? r_first_y : w_in_y;
    assign w_root_start = (r_state == S_MUL) & w_mac_stat.done & r_job_len;

    prm_seg_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    (w_op_bx),
        .i_by    (w_op_by),
        .o_cross (w_cross),
        .o_sumsq (w_sumsq),
        .o_stat  (w_mac_stat)
    );

    prm_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_sumsq),
        .o_root     (w_root),
        .o_stat     (w_root_stat)
    );

    // The shoelace sum saturates to its signed range on every edge.
    assign w_cross_ext = {r_cross_sum[CROSS_W-1], r_cross_sum}
                       + {{(CROSS_W + 1 - PROD_W){w_cross[PROD_W-1]}}, w_cross};
    always_comb begin
        if (w_cross_ext[CROSS_W] != w_cross_ext[CROSS_W-1]) begin
            w_cross_sat = w_cross_ext[CROSS_W] ? {1'b1, {(CROSS_W - 1){1'b0}}}
                                               : {1'b0, {(CROSS_W - 1){1'b1}}};
        end else begin
            w_cross_sat = w_cross_ext[CROSS_W-1:0];
        end
    end

    // The perimeter saturates at its all-ones value.
    assign w_len_ext = {1'b0, r_len_sum} + {{(LEN_W + 1 - ROOT_W){1'b0}}, w_root};
    assign w_len_sat = w_len_ext[LEN_W] ? {LEN_W{1'b1}} : w_len_ext[LEN_W-1:0];

    // Magnitude of the sum; the most negative sum exceeds the area range.
    assign w_abs  = r_cross_sum[CROSS_W-1] ? (~r_cross_sum + 1'b1) : r_cross_sum;
    assign w_area = w_abs[CROSS_W-1] ? {AREA_W{1'b1}} : w_abs[AREA_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (w_edge) begin
                        n_state = S_MUL;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_mac_stat.done) begin
                    n_state = r_job_len ? S_ROOT : S_EMIT;
                end
            end
            S_ROOT: begin
                if (w_root_stat.done) begin
                    if (r_job_close) begin
                        n_state = S_EMIT;
                    end else if (r_pend_close) begin
                        n_state = S_LAUNCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ring       <= 1'b0;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_cross_sum  <= '0;
            r_len_sum    <= '0;
            r_job_close  <= 1'b0;
            r_job_len    <= 1'b0;
            r_pend_close <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_ring <= i_cfg_data;
            end

            if (w_in_fire) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
                if (w_edge) begin
                    r_job_close  <= 1'b0;
                    r_job_len    <= 1'b1;
                    r_pend_close <= i_s_axis_tlast;
                end
            end

            if (r_state == S_LAUNCH) begin
                r_job_close  <= 1'b1;
                r_job_len    <= r_ring;
                r_pend_close <= 1'b0;
            end

            if ((r_state == S_MUL) && w_mac_stat.done) begin
                r_cross_sum <= w_cross_sat;
            end

            if ((r_state == S_ROOT) && w_root_stat.done) begin
                r_len_sum <= w_len_sat;
            end

            if (o_m_axis_tvalid && i_m_axis_tready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_overflow  <= 1'b0;
                r_cross_sum <= '0;
                r_len_sum   <= '0;
            end
        end
    end

    // Vertex registers, bounding box and the result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prev_x <= w_in_x;
            r_prev_y <= w_in_y;
            if (r_count == '0) begin
                r_first_x <= w_in_x;
                r_first_y <= w_in_y;
                r_min_x   <= w_in_x;
                r_max_x   <= w_in_x;
                r_min_y   <= w_in_y;
                r_max_y   <= w_in_y;
            end else begin
                if (w_in_x < r_min_x) begin
                    r_min_x <= w_in_x;
                end
                if (w_in_x > r_max_x) begin
                    r_max_x <= w_in_x;
                end
                if (w_in_y < r_min_y) begin
                    r_min_y <= w_in_y;
                end
                if (w_in_y > r_max_y) begin
                    r_max_y <= w_in_y;
                end
            end
        end

        if (w_emit) begin
            r_res_min_x <= r_min_x;
            r_res_max_x <= r_max_x;
            r_res_min_y <= r_min_y;
            r_res_max_y <= r_max_y;
            r_res_area  <= w_area;
            r_res_cw    <= r_ring & r_cross_sum[CROSS_W-1];
            r_res_perim <= r_len_sum;
            r_res_total <= r_count;
            r_res_ovf   <= r_overflow;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_res_ovf, r_res_total, r_res_perim,
                              r_res_cw, r_res_area, r_res_max_y, r_res_min_y,
                              r_res_max_x, r_res_min_x};

    // Vertices are taken only when both serial units are quiet.
    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!w_mac_stat.busy && !w_root_stat.busy))
        else $error("vertex accepted while an edge is still being computed");

    a_mac_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_stat.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside the multiply state");

    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_stat.done |-> (r_state == S_ROOT))
        else $error("square root finished outside the root state");

    a_overflow_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_VERTICES)))
        else $error("overflow flagged before the vertex limit was reached");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count passed the limit");

endmodule

// ===== verif/polygon_ring_metrics_checker.sv =====
`timescale 1ns / 1ps

module polygon_ring_metrics_checker import prm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vtx_valid,
    input  logic                   i_vtx_ready,
    input  logic [IN_TDATA_W-1:0]  i_vtx_data,    // vertex_x, vertex_y
    input  logic                   i_vtx_last,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,    // box, area, cw, perimeter, count, ovf
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic                   i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results_seen
);

    // Bit positions of the result fields, lowest first.
    localparam int MIN_X_LSB = 0;
    localparam int MAX_X_LSB = COORD_BITS;
    localparam int MIN_Y_LSB = 2 * COORD_BITS;
    localparam int MAX_Y_LSB = 3 * COORD_BITS;
    localparam int AREA_LSB  = 4 * COORD_BITS;
    localparam int CW_BIT    = AREA_LSB + AREA_W;
    localparam int PERIM_LSB = CW_BIT + 1;
    localparam int COUNT_LSB = PERIM_LSB + LEN_W;
    localparam int OVF_BIT   = COUNT_LSB + CNT_W;

    localparam longint SHOELACE_MAX = (longint'(1) << (CROSS_W - 1)) - 1;
    localparam longint SHOELACE_MIN = -(longint'(1) << (CROSS_W - 1));
    localparam longint AREA_MAX     = (longint'(1) << AREA_W) - 1;
    localparam longint LENGTH_MAX   = (longint'(1) << LEN_W) - 1;

    typedef struct {
        longint min_x;
        longint max_x;
        longint min_y;
        longint max_y;
        longint double_area;
        bit     clockwise;
        longint perimeter;
        longint vertex_total;
        bit     overflowed;
    } t_shape_metrics;

    longint         first_x, first_y, last_x, last_y;
    longint         lo_x, hi_x, lo_y, hi_y;
    longint         shoelace_sum;
    longint         perimeter_sum;
    int             vertex_count;
    bit             dropped_vertex;
    bit             ring_closed;
    t_shape_metrics pending_shapes[$];
    int             err_count = 0;
    int             result_count = 0;

    // Segment length as floor(sqrt(d) * 2^FRAC_BITS), digit by digit.
    function automatic longint segment_length_q(longint ax, longint ay,
                                                longint bx, longint by);
        longint unsigned dx, dy, radicand, root, rest, trial;
        int              i;
        dx = (bx >= ax) ? bx - ax : ax - bx;
        dy = (by >= ay) ? by - ay : ay - by;
        radicand = dx * dx + dy * dy;
        root = 0;
        rest = 0;
        for (i = 31; i >= -FRAC_BITS; i--) begin
            rest = rest << 2;
            if (i >= 0)
                rest = rest | ((radicand >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rest >= trial) begin
                rest = rest - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    task automatic add_edge(input longint ax, input longint ay, input longint bx,
                            input longint by, input bit with_length);
        longint total, seg;
        total = shoelace_sum + (ax * by - ay * bx);
        if (total > SHOELACE_MAX)
            total = SHOELACE_MAX;
        if (total < SHOELACE_MIN)
            total = SHOELACE_MIN;
        shoelace_sum = total;
        if (with_length) begin
            seg = segment_length_q(ax, ay, bx, by);
            if (seg > LENGTH_MAX - perimeter_sum)
                perimeter_sum = LENGTH_MAX;
            else
                perimeter_sum = perimeter_sum + seg;
        end
    endtask

    task automatic clear_shape();
        first_x = 0; first_y = 0; last_x = 0; last_y = 0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
        shoelace_sum   = 0;
        perimeter_sum  = 0;
        vertex_count   = 0;
        dropped_vertex = 0;
    endtask

    task automatic absorb_vertex(input longint x, input longint y, input bit closes);
        t_shape_metrics m;
        longint         area;
        if (vertex_count >= MAX_VERTICES) begin
            dropped_vertex = 1;
        end else begin
            if (vertex_count == 0) begin
                first_x = x; first_y = y;
                lo_x = x; hi_x = x; lo_y = y; hi_y = y;
            end else begin
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
                add_edge(last_x, last_y, x, y, 1'b1);
            end
            last_x = x;
            last_y = y;
            vertex_count++;
        end
        if (closes) begin
            // The closing edge always counts for the area, for the length only in a ring.
            add_edge(last_x, last_y, first_x, first_y, ring_closed);
            area = (shoelace_sum < 0) ? -shoelace_sum : shoelace_sum;
            if (area > AREA_MAX)
                area = AREA_MAX;
            m.min_x        = lo_x;
            m.max_x        = hi_x;
            m.min_y        = lo_y;
            m.max_y        = hi_y;
            m.double_area  = area;
            m.clockwise    = ring_closed && (shoelace_sum < 0);
            m.perimeter    = perimeter_sum;
            m.vertex_total = vertex_count % (1 << CNT_W);
            m.overflowed   = dropped_vertex;
            pending_shapes.insert(pending_shapes.size(), m);
            clear_shape();
        end
    endtask

    task automatic check_field(input string name, input longint expected,
                               input longint actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            err_count++;
        end
    endtask

    task automatic check_result();
        t_shape_metrics m;
        if (pending_shapes.size() == 0) begin
            $error("result transfer arrived with no shape pending");
            err_count++;
        end else begin
            m = pending_shapes.pop_front();
            result_count++;
            check_field("box_min_x", m.min_x, signed'(i_res_data[MIN_X_LSB +: COORD_BITS]));
            check_field("box_max_x", m.max_x, signed'(i_res_data[MAX_X_LSB +: COORD_BITS]));
            check_field("box_min_y", m.min_y, signed'(i_res_data[MIN_Y_LSB +: COORD_BITS]));
            check_field("box_max_y", m.max_y, signed'(i_res_data[MAX_Y_LSB +: COORD_BITS]));
            check_field("double_area", m.double_area, i_res_data[AREA_LSB +: AREA_W]);
            check_field("is_clockwise", m.clockwise, i_res_data[CW_BIT]);
            check_field("perimeter", m.perimeter, i_res_data[PERIM_LSB +: LEN_W]);
            check_field("vertex_total", m.vertex_total, i_res_data[COUNT_LSB +: CNT_W]);
            check_field("overflowed", m.overflowed, i_res_data[OVF_BIT]);
            check_field("zero_fill", 0, i_res_data[OUT_TDATA_W-1 -: OUT_PAD_W]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shape();
            ring_closed = 1'b0;
            pending_shapes.delete();
        end else begin
            // A result is checked before a new shape may be queued in the same cycle.
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_cfg_valid && i_cfg_ready)
                ring_closed = i_cfg_data;
            if (i_vtx_valid && i_vtx_ready)
                absorb_vertex(signed'(i_vtx_data[0 +: COORD_BITS]),
                              signed'(i_vtx_data[COORD_BITS +: COORD_BITS]), i_vtx_last);
        end
        o_errors       <= err_count;
        o_pending      <= pending_shapes.size();
        o_results_seen <= result_count;
    end

endmodule

// ===== verif/tb_polygon_ring_metrics_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the polygon ring metrics block. The checker next to
// the block watches all three channels, predicts each shape result and counts
// mismatches; this module only produces traffic and reports the outcome.
module tb_polygon_ring_metrics_top;
    import prm_pkg::*;

    // The run sends about 1,550 vertices. The limit is about ten times what a
    // correct run needs even if every vertex closed a ring, plus the receiver
    // hold-off and the gaps between phases.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // Quiet gap after the last result of a phase, before the ring mode changes.
    localparam int SETTLE_CYCLES = 150;

    // Long receiver hold-off, enough to park one result in the output
    // register and stall the input behind a second finished shape.
    localparam int HOLDOFF_CYCLES = 1500;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 245;
    localparam int STEADY_PHASE = 2;
    localparam int STALL_PHASE  = 3;

    localparam bit RING_OPEN   = 1'b0;
    localparam bit RING_CLOSED = 1'b1;

    // Ring mode per random phase, phase 0 in the lowest bit.
    localparam bit [PHASES-1:0] PHASE_RING = 6'b010110;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Coordinate styles for random shapes.
    localparam int STYLE_FULL    = 0;
    localparam int STYLE_NEAR    = 1;
    localparam int STYLE_EXTREME = 2;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   vtx_valid = 1'b0;
    logic                   vtx_ready;
    logic [IN_TDATA_W-1:0]  vtx_data = '0;    // vertex_x, vertex_y
    logic                   vtx_last = 1'b0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;         // box_min_x .. overflowed, zero fill
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data = 1'b0;

    int          errors;
    int          pending;
    int          results_seen;
    int unsigned cycle_count = 0;
    int unsigned vertices_sent = 0;

    // When set, neither side inserts random idle cycles.
    bit steady = 1'b0;

    // The stimulus asks for a hold-off by bumping the request count; the
    // receiver process serves one request at a time.
    int holdoff_requested = 0;
    int holdoff_served = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    polygon_ring_metrics_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (vtx_valid),
        .o_s_axis_tready (vtx_ready),
        .i_s_axis_tdata  (vtx_data),
        .i_s_axis_tlast  (vtx_last),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    polygon_ring_metrics_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_vtx_valid    (vtx_valid),
        .i_vtx_ready    (vtx_ready),
        .i_vtx_data     (vtx_data),
        .i_vtx_last     (vtx_last),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_res_data     (res_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // Watchdog: a hung handshake or a result that never comes ends up here.
    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver side. Ready drops in about a third of the cycles, stays high
    // during the steady phase, and stays low for a whole hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (holdoff_requested != holdoff_served) begin
                res_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
                holdoff_served++;
            end else if (steady) begin
                res_ready <= 1'b1;
            end else begin
                res_ready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // One vertex transfer. Idle cycles come first, so valid stays high from one
    // transfer to the next whenever no gap is drawn.
    task automatic send_vertex(input t_coord x, input t_coord y, input bit closes);
        while (!steady && $urandom_range(0, 99) < 33) begin
            vtx_valid <= 1'b0;
            @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_data  <= {y, x};
        vtx_last  <= closes;
        @(posedge clk);
        while (!vtx_ready)
            @(posedge clk);
        vertices_sent++;
    endtask

    // The ring mode register is only written while no shape is in flight.
    task automatic write_ring_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering vertices, wait for every predicted result, then leave a
    // quiet gap before the next phase.
    task automatic finish_phase();
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_coord pick_coord(input int style);
        int unsigned roll;
        roll = $urandom_range(0, 3);
        case (style)
            STYLE_NEAR: begin
                return t_coord'(int'($urandom_range(0, 511)) - 256);
            end
            STYLE_EXTREME: begin
                if (roll == 0)
                    return COORD_MIN;
                else if (roll == 1)
                    return COORD_MAX;
                return t_coord'($urandom());
            end
            default: begin
                return t_coord'($urandom());
            end
        endcase
    endfunction

    // Mostly short shapes, now and then a single point or a long outline.
    task automatic send_random_shape();
        int unsigned roll, len, style, k;
        roll  = $urandom_range(0, 99);
        style = $urandom_range(STYLE_FULL, STYLE_EXTREME);
        if (roll < 8)
            len = 1;
        else if (roll < 80)
            len = $urandom_range(2, 8);
        else if (roll < 95)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 60);
        for (k = 0; k < len; k++)
            send_vertex(pick_coord(style), pick_coord(style), k == len - 1);
    endtask

    task automatic run_shape_mix(input int unsigned budget);
        int unsigned start;
        start = vertices_sent;
        while (vertices_sent - start < budget)
            send_random_shape();
    endtask

    initial begin
        int k;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Open polylines: a lone vertex at opposite corners of the grid, and a
        // triangle spanning the full range whose area still counts the
        // closing edge while the perimeter leaves it out.
        write_ring_mode(RING_OPEN);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        finish_phase();

        // Closed rings: a clockwise square, a counterclockwise full-range
        // triangle, a lone vertex, the longest possible segment, and a
        // repeated vertex that gives zero length.
        write_ring_mode(RING_CLOSED);
        send_vertex(t_coord'(0), t_coord'(0), 1'b0);
        send_vertex(t_coord'(0), t_coord'(10), 1'b0);
        send_vertex(t_coord'(10), t_coord'(10), 1'b0);
        send_vertex(t_coord'(10), t_coord'(0), 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(t_coord'(0), t_coord'(-1), 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        send_vertex(t_coord'(5), t_coord'(-5), 1'b0);
        send_vertex(t_coord'(5), t_coord'(-5), 1'b1);
        finish_phase();

        // Random phases alternate the ring mode. One runs without any idle
        // cycles; one starts with a long receiver hold-off while short
        // shapes keep coming, so the finished results back up into the input.
        for (k = 0; k < PHASES; k++) begin
            write_ring_mode(PHASE_RING[k]);
            steady = (k == STEADY_PHASE);
            if (k == STALL_PHASE) begin
                holdoff_requested++;
                repeat (14) begin
                    send_vertex(pick_coord(STYLE_NEAR), pick_coord(STYLE_NEAR), 1'b0);
                    send_vertex(pick_coord(STYLE_NEAR), pick_coord(STYLE_NEAR), 1'b1);
                end
            end
            run_shape_mix(PHASE_ITEMS);
            finish_phase();
        end
        steady = 1'b0;

        $display("Covered %0d vertex transfers and %0d shape results in open and closed mode,",
                 vertices_sent, results_seen);
        $display("including grid extremes, single points, a run with no idling and a long stall.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
